@@ rtl/qte_pkg.sv @@
// Shared types, constants and helpers for the quaternion to Euler angle block.
// No dependencies.
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CW = 40;
  localparam int SQ_STEPS = 31;
  localparam int SQW = 62;
  localparam int RW = 31;

  localparam logic [14:0] THR_RESET = 15'd14713;
  localparam logic signed [15:0] PITCH_NORTH = 16'sh4000;
  localparam logic signed [15:0] PITCH_SOUTH = -16'sh4000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef logic signed [CW-1:0] cval_t;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  typedef struct packed {
    cval_t              yaw_y;
    cval_t              yaw_x;
    cval_t              roll_y;
    cval_t              roll_x;
    logic signed [31:0] s;
    pole_t              pole;
  } side_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // 32-bit binary angle to 16 bits, round half up, wrapping
  function automatic logic signed [15:0] to16(input logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h0000_8000;
    return $signed(r[31:16]);
  endfunction

endpackage

@@ rtl/qte_if.sv @@
// Valid/ready channel interfaces for quaternion input, angle output and config.
// No dependencies.
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic [1:0]         pole_case;
  modport source(output valid, yaw_angle, pitch_angle, roll_angle, pole_case, input ready);
  modport sink(input valid, yaw_angle, pitch_angle, roll_angle, pole_case, output ready);
endinterface

interface qte_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] pole_threshold;
  modport source(output valid, pole_threshold, input ready);
  modport sink(input valid, pole_threshold, output ready);
endinterface

@@ rtl/qte_front.sv @@
// Front end: component products, test term, pole decision, CORDIC operands, s squared.
// Depends on qte_pkg.
module qte_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  logic signed [15:0] w,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  input  logic [14:0]        thr,
  output logic               vld_out,
  output qte_pkg::side_t     side,
  output logic [60:0]        sq
);
  import qte_pkg::*;

  logic               v1, v2;
  logic signed [31:0] pxz, pyw, pzw, pxy, pzz, pyy, pxw, pzy, pxx;
  logic signed [15:0] w1, x1;
  side_t              side2;

  logic signed [32:0] t, lim;
  logic signed [34:0] yn, yd, rn, rd, s2, one;
  logic signed [31:0] s_sat;
  logic               north, south;
  side_t              side_next;
  logic signed [63:0] sq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vld_in;
    end
    if (en) begin
      pxz <= x * z;
      pyw <= y * w;
      pzw <= z * w;
      pxy <= x * y;
      pzz <= z * z;
      pyy <= y * y;
      pxw <= x * w;
      pzy <= z * y;
      pxx <= x * x;
      w1  <= w;
      x1  <= x;
    end
  end

  always_comb begin
    one   = 35'sd1 <<< 30;
    t     = 33'(pxz) + 33'(pyw);
    lim   = $signed({3'b000, thr, 15'b0});
    north = t > lim;
    south = t < -lim;
    yn    = (35'(pzw) - 35'(pxy)) <<< 1;
    yd    = one - ((35'(pzz) + 35'(pyy)) <<< 1);
    rn    = (35'(pxw) - 35'(pzy)) <<< 1;
    rd    = one - ((35'(pxx) + 35'(pyy)) <<< 1);
    s2    = 35'(t) <<< 1;
    if (s2 > one) begin
      s_sat = 32'(one);
    end else if (s2 < -one) begin
      s_sat = 32'(-one);
    end else begin
      s_sat = 32'(s2);
    end
    side_next.s      = s_sat;
    side_next.roll_y = CW'(rn);
    side_next.roll_x = CW'(rd);
    if (north || south) begin
      side_next.yaw_y = CW'(x1);
      side_next.yaw_x = CW'(w1);
      side_next.pole  = north ? POLE_NORTH : POLE_SOUTH;
    end else begin
      side_next.yaw_y = CW'(yn);
      side_next.yaw_x = CW'(yd);
      side_next.pole  = POLE_NONE;
    end
  end

  assign sq_full = side2.s * side2.s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2      <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      v2      <= v1;
      vld_out <= v2;
    end
    if (en) begin
      side2 <= side_next;
      side  <= side2;
      sq    <= sq_full[60:0];
    end
  end

endmodule

@@ rtl/qte_sqrt.sv @@
// Pipelined integer square root of 2^60 - sq, one result bit per stage.
// Depends on qte_pkg.
module qte_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    vld_in,
  input  logic [60:0]             sq,
  input  qte_pkg::side_t          side_in,
  output logic                    vld_out,
  output logic [qte_pkg::RW-1:0]  root,
  output qte_pkg::side_t          side_out
);
  import qte_pkg::*;

  logic [SQW-1:0] n_a [SQ_STEPS];
  logic [SQW-1:0] r_a [SQ_STEPS];
  logic           v_a [SQ_STEPS];
  side_t          sd_a [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_stg
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [SQW-1:0] n_in, r_in, cand;
    logic           v_in;
    side_t          s_in;

    if (j == 0) begin : g_first
      assign n_in = (SQW'(1) << 60) - SQW'(sq);
      assign r_in = '0;
      assign v_in = vld_in;
      assign s_in = side_in;
    end else begin : g_rest
      assign n_in = n_a[j-1];
      assign r_in = r_a[j-1];
      assign v_in = v_a[j-1];
      assign s_in = sd_a[j-1];
    end

    assign cand = r_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[j] <= 1'b0;
      end else if (en) begin
        v_a[j] <= v_in;
      end
      if (en) begin
        if (n_in >= cand) begin
          n_a[j] <= n_in - cand;
          r_a[j] <= (r_in >> 1) + BIT;
        end else begin
          n_a[j] <= n_in;
          r_a[j] <= r_in >> 1;
        end
        sd_a[j] <= s_in;
      end
    end
  end

  assign vld_out  = v_a[SQ_STEPS-1];
  assign root     = r_a[SQ_STEPS-1][RW-1:0];
  assign side_out = sd_a[SQ_STEPS-1];

endmodule

@@ rtl/qte_cordic.sv @@
// Pipelined CORDIC vectoring atan2(y, x) giving a 32-bit binary angle.
// Depends on qte_pkg.
module qte_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  qte_pkg::cval_t  y_in,
  input  qte_pkg::cval_t  x_in,
  output logic            vld_out,
  output logic [31:0]     ang
);
  import qte_pkg::*;

  cval_t       px, py;
  logic [31:0] pa;
  logic        pz, pv;

  cval_t       xa [CORDIC_STAGES];
  cval_t       ya [CORDIC_STAGES];
  logic [31:0] aa [CORDIC_STAGES];
  logic        za [CORDIC_STAGES];
  logic        va [CORDIC_STAGES];

  // half-turn pre-rotation for negative x
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= vld_in;
    end
    if (en) begin
      pz <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        px <= -x_in;
        py <= -y_in;
        pa <= HALF_TURN;
      end else begin
        px <= x_in;
        py <= y_in;
        pa <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stg
    localparam int K = i % 32;
    cval_t       xi, yi, xs, ys;
    logic [31:0] ai;
    logic        zi, vi;

    if (i == 0) begin : g_first
      assign xi = px;
      assign yi = py;
      assign ai = pa;
      assign zi = pz;
      assign vi = pv;
    end else begin : g_rest
      assign xi = xa[i-1];
      assign yi = ya[i-1];
      assign ai = aa[i-1];
      assign zi = za[i-1];
      assign vi = va[i-1];
    end

    assign xs = xi >>> K;
    assign ys = yi >>> K;

    always_ff @(posedge clk) begin
      if (rst) begin
        va[i] <= 1'b0;
      end else if (en) begin
        va[i] <= vi;
      end
      if (en) begin
        za[i] <= zi;
        if (yi > 0) begin
          xa[i] <= xi + ys;
          ya[i] <= yi - xs;
          aa[i] <= ai + ATAN_TAB[K];
        end else begin
          xa[i] <= xi - ys;
          ya[i] <= yi + xs;
          aa[i] <= ai - ATAN_TAB[K];
        end
      end
    end
  end

  assign vld_out = va[CORDIC_STAGES-1];
  assign ang     = za[CORDIC_STAGES-1] ? 32'd0 : aa[CORDIC_STAGES-1];

endmodule

@@ rtl/quaternion_to_euler.sv @@
// Top level: quaternion (Q1.15) to yaw/pitch/roll binary angles with pole detection.
// Depends on qte_pkg, qte_if, qte_front, qte_sqrt, qte_cordic.
//
// Channels: quat (sink) takes one quaternion item per accepted handshake;
// euler (source) delivers yaw, pitch, roll and the pole case for each item,
// in order; cfg (sink) writes pole_threshold and is always ready.
// Throughput: one item per cycle while euler is ready.
// Pipeline stages from accept to valid output: three front stages, one stage per
// root bit of the square root, a pre-rotation stage plus one stage per CORDIC
// iteration, and the output register.
// The whole pipeline advances together; when euler stalls with a result held,
// quat.ready drops and every stage holds its item, bubbles included.
// Reset clears all valid bits and loads pole_threshold with 14713.
// pole_threshold should be written only while no item is in flight.
module quaternion_to_euler (
  input logic       clk,
  input logic       rst,
  qte_in_if.sink    quat,
  qte_out_if.source euler,
  qte_cfg_if.sink   cfg
);
  import qte_pkg::*;

  logic        adv;
  logic [14:0] thr;

  logic        f_vld;
  side_t       f_side;
  logic [60:0] f_sq;

  logic        s_vld;
  logic [RW-1:0] s_root;
  side_t       s_side;

  logic        c_vld;
  logic [31:0] yaw_ang, pitch_ang, roll_ang;
  pole_t       pd [CORDIC_STAGES+1];
  logic [31:0] yaw32;

  assign adv        = !euler.valid || euler.ready;
  assign quat.ready = adv;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.pole_threshold;
    end
  end

  qte_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (quat.valid),
    .w       (quat.quat_w),
    .x       (quat.quat_x),
    .y       (quat.quat_y),
    .z       (quat.quat_z),
    .thr     (thr),
    .vld_out (f_vld),
    .side    (f_side),
    .sq      (f_sq)
  );

  qte_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (f_vld),
    .sq       (f_sq),
    .side_in  (f_side),
    .vld_out  (s_vld),
    .root     (s_root),
    .side_out (s_side)
  );

  qte_cordic u_yaw (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (s_vld),
    .y_in    (s_side.yaw_y),
    .x_in    (s_side.yaw_x),
    .vld_out (c_vld),
    .ang     (yaw_ang)
  );

  qte_cordic u_pitch (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (s_vld),
    .y_in    (CW'(s_side.s)),
    .x_in    ($signed(CW'(s_root))),
    .vld_out (),
    .ang     (pitch_ang)
  );

  qte_cordic u_roll (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (s_vld),
    .y_in    (s_side.roll_y),
    .x_in    (s_side.roll_x),
    .vld_out (),
    .ang     (roll_ang)
  );

  // pole case rides alongside the CORDIC pipes
  always_ff @(posedge clk) begin
    if (adv) begin
      pd[0] <= s_side.pole;
      for (int i = 1; i <= CORDIC_STAGES; i++) begin
        pd[i] <= pd[i-1];
      end
    end
  end

  always_comb begin
    case (pd[CORDIC_STAGES])
      POLE_NORTH: yaw32 = yaw_ang << 1;
      POLE_SOUTH: yaw32 = 32'd0 - (yaw_ang << 1);
      default:    yaw32 = yaw_ang;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      euler.valid <= 1'b0;
    end else if (adv) begin
      euler.valid <= c_vld;
    end
    if (adv) begin
      euler.yaw_angle <= to16(yaw32);
      euler.pole_case <= pd[CORDIC_STAGES];
      case (pd[CORDIC_STAGES])
        POLE_NORTH: begin
          euler.pitch_angle <= PITCH_NORTH;
          euler.roll_angle  <= '0;
        end
        POLE_SOUTH: begin
          euler.pitch_angle <= PITCH_SOUTH;
          euler.roll_angle  <= '0;
        end
        default: begin
          euler.pitch_angle <= to16(pitch_ang);
          euler.roll_angle  <= to16(roll_ang);
        end
      endcase
    end
  end

  a_pole_roll: assert property (@(posedge clk) disable iff (rst)
    euler.valid && (euler.pole_case != POLE_NONE) |-> euler.roll_angle == 16'sd0)
    else $error("roll not zero in pole case");

  a_north_pitch: assert property (@(posedge clk) disable iff (rst)
    euler.valid && (euler.pole_case == POLE_NORTH) |-> euler.pitch_angle == PITCH_NORTH)
    else $error("north pole pitch wrong");

  a_south_pitch: assert property (@(posedge clk) disable iff (rst)
    euler.valid && (euler.pole_case == POLE_SOUTH) |-> euler.pitch_angle == PITCH_SOUTH)
    else $error("south pole pitch wrong");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    euler.valid && !euler.ready |-> !quat.ready)
    else $error("input taken while output stalled");

endmodule
